[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the matrix block.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, suspended during reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs while reset is high.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/mtt_pkg.sv]
// Package for the A times A-transpose block: sizes, codes and the store port types.
// Depends on nothing; used by the interfaces, the store and the top level.
package mtt_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ELEM_W   = 16;
   localparam int PROD_W   = 2 * ELEM_W;
   localparam int SUM_W    = 38;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'd1;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } store_rd_type;

endpackage

[rtl/mtt_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on mtt_pkg for the field widths.
interface mtt_req_if import mtt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [ROW_W-1:0]         row_index;
   logic [COL_W-1:0]         col_index;
   logic [ROW_W-1:0]         partner_row;
   logic signed [ELEM_W-1:0] element_value;

   modport source (output valid, action, row_index, col_index, partner_row, element_value,
                   input ready);
   modport sink   (input valid, action, row_index, col_index, partner_row, element_value,
                   output ready);
endinterface

interface mtt_rsp_if import mtt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] product_sum;

   modport source (output valid, product_sum, input ready);
   modport sink   (input valid, product_sum, output ready);
endinterface

[rtl/matrix_times_own_transpose_top.sv]
// Channel   Dir  Beat carries
// req_bus   in   action, row_index, col_index, partner_row, element_value
// rsp_bus   out  product_sum (one beat per read request, none per write)
// csr_*     in   write enable, register index, 7-bit data
//
// A write beat leaves ready high. An in-range read with nonzero col_count keeps
// ready low through one store read pair and one multiply-accumulate per column
// (col_count capped at 64 columns), the pipeline drain and the result load. A read
// off the matrix or with col_count zero keeps it low only for the result load.
// A stalled response holds the sequencer in DONE until the output register frees.
// Reset (synchronous) clears sequencer state and valid flags and sets both size registers to 64, not the store.
// Depends on mtt_pkg, mtt_if, mtt_store and assert_macros.svh.
`include "assert_macros.svh"

module matrix_times_own_transpose_top import mtt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mtt_req_if.sink              req_bus,
   mtt_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CFG_W-1:0]        row_count_ff, col_count_ff;
   logic [ROW_W-1:0]        ri_ff, ri_in;
   logic [ROW_W-1:0]        pj_ff, pj_in;
   logic [COL_W-1:0]        k_ff, k_in;
   logic [COL_W-1:0]        last_k_ff, last_k_in;
   logic                    rd_v_ff, prod_v_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  rsp_sum_ff;

   logic [CFG_W-1:0]        rows_sat, cols_sat;
   logic                    req_fire, read_fire, in_range, issue, load_rsp;
   store_wr_type            st_wr;
   store_rd_type            st_rd;
   logic signed [ELEM_W-1:0] rd_data_a, rd_data_b;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_RESET;
         col_count_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff <= csr_wdata;
            CSR_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rows_sat = (row_count_ff > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_ff;
   assign cols_sat = (col_count_ff > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : col_count_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign read_fire     = req_fire && (req_bus.action == ACTION_READ);
   assign in_range      = (CFG_W'(req_bus.row_index) < rows_sat)
                       && (CFG_W'(req_bus.partner_row) < rows_sat)
                       && (cols_sat != '0);
   assign issue         = (state_ff == S_ISSUE);
   assign load_rsp      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // Store ports
   always_comb begin
      st_wr.en     = req_fire && (req_bus.action == ACTION_WRITE);
      st_wr.addr   = {req_bus.row_index, req_bus.col_index};
      st_wr.data   = req_bus.element_value;
      st_rd.en     = issue;
      st_rd.addr_a = {ri_ff, k_ff};
      st_rd.addr_b = {pj_ff, k_ff};
   end

   mtt_store u_store (
      .clock     (clock),
      .wr        (st_wr),
      .rd        (st_rd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ri_in        = ri_ff;
      pj_in        = pj_ff;
      k_in         = k_ff;
      last_k_in    = last_k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (read_fire) begin
               ri_in     = req_bus.row_index;
               pj_in     = req_bus.partner_row;
               k_in      = '0;
               last_k_in = COL_W'(cols_sat - CFG_W'(1));
               state_in  = in_range ? S_ISSUE : S_DONE;
            end
         end
         S_ISSUE: begin
            k_in = k_ff + COL_W'(1);
            if (k_ff == last_k_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_v_ff      <= issue;
         prod_v_ff    <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: indices, shared multiplier, accumulator, output register
   always_ff @(posedge clock) begin
      ri_ff     <= ri_in;
      pj_ff     <= pj_in;
      k_ff      <= k_in;
      last_k_ff <= last_k_in;
      prod_ff   <= PROD_W'(rd_data_a) * PROD_W'(rd_data_b);
      if (read_fire) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + SUM_W'(prod_ff);
      end
      if (load_rsp) begin
         rsp_sum_ff <= acc_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.product_sum = rsp_sum_ff;

   `ASSERT_CLK(a_pipe_only_busy,
      (rd_v_ff || prod_v_ff) |-> (state_ff == S_ISSUE || state_ff == S_DRAIN),
      "multiply pipeline active outside a read")
   `ASSERT_CLK(a_k_in_bounds,
      (state_ff == S_ISSUE) |-> (k_ff <= last_k_ff),
      "column counter ran past the last column")
   `ASSERT_CLK(a_done_holds,
      (state_ff == S_DONE && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == S_DONE),
      "result left DONE while the output register was still full")

endmodule

[rtl/mtt_store.sv]
// Element store for matrix A: one write port, two registered read ports.
// Depends on mtt_pkg for the depth and the port structs.
module mtt_store import mtt_pkg::*; (
   input  logic                     clock,
   input  store_wr_type             wr,
   input  store_rd_type             rd,
   output logic signed [ELEM_W-1:0] rd_data_a,
   output logic signed [ELEM_W-1:0] rd_data_b
);

   logic [ELEM_W-1:0] store_ff [0:DEPTH-1];
   logic [ELEM_W-1:0] rd_a_ff;
   logic [ELEM_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= store_ff[rd.addr_a];
         rd_b_ff <= store_ff[rd.addr_b];
      end
   end

   assign rd_data_a = $signed(rd_a_ff);
   assign rd_data_b = $signed(rd_b_ff);

endmodule
